### rtl/core/stwp_pkg.sv
// Shared types and constants for the stopwatch timer pool.
// No dependencies; every other file of the block imports this package.
`timescale 1ns / 1ps

package stwp_pkg;

    localparam int POOL_SIZE_DEF = 8;
    localparam int ID_W          = 8;
    localparam int TIME_W        = 32;
    localparam int OP_W          = 2;
    localparam int ST_W          = 2;

    typedef enum logic [OP_W-1:0] {
        OP_START   = 2'd0,
        OP_QUERY   = 2'd1,
        OP_RESTART = 2'd2,
        OP_CLOSE   = 2'd3
    } op_t;

    typedef enum logic [ST_W-1:0] {
        ST_OK      = 2'd0,
        ST_FULL    = 2'd1,
        ST_INVALID = 2'd2
    } status_t;

    typedef enum logic [1:0] {
        S_IDLE = 2'd0,
        S_READ = 2'd1,
        S_CALC = 2'd2
    } state_t;

    // Slot command toward the active-flag bank.
    typedef struct packed {
        logic       set_en;
        logic       clr_en;
        logic [5:0] idx;
    } alloc_cmd_t;

    // Slot command toward the timer memories.
    typedef struct packed {
        logic       rd_en;
        logic       wr_timeout;
        logic       wr_checkpoint;
        logic [5:0] addr;
    } mem_cmd_t;

    // Index width for a pool of n slots, at least one bit.
    function automatic int idx_w(input int n);
        idx_w = (n > 1) ? $clog2(n) : 1;
    endfunction

endpackage

### rtl/core/stwp_if.sv
// Request and response channel interfaces of the stopwatch timer pool.
// Depends on stwp_pkg for field widths.
`timescale 1ns / 1ps

interface stwp_req_if;
    import stwp_pkg::*;

    logic              valid;
    logic              ready;
    logic [OP_W-1:0]   operation;
    logic [ID_W-1:0]   timer_id;
    logic [TIME_W-1:0] timeout_ms;
    logic [TIME_W-1:0] now_ms;

    modport source (output valid, operation, timer_id, timeout_ms, now_ms, input ready);
    modport sink   (input valid, operation, timer_id, timeout_ms, now_ms, output ready);
endinterface

interface stwp_rsp_if;
    import stwp_pkg::*;

    logic              valid;
    logic              ready;
    logic [ST_W-1:0]   status;
    logic [ID_W-1:0]   slot_granted;
    logic [TIME_W-1:0] count_value;

    modport source (output valid, status, slot_granted, count_value, input ready);
    modport sink   (input valid, status, slot_granted, count_value, output ready);
endinterface

### rtl/core/stwp_alloc.sv
// Active-flag bank of the timer pool with a lowest-free-slot encoder.
// Depends on stwp_pkg.
`timescale 1ns / 1ps

module stwp_alloc #(
    parameter int POOL_SIZE = stwp_pkg::POOL_SIZE_DEF
) (
    input  logic                                     clk,
    input  logic                                     rst_n,
    input  stwp_pkg::alloc_cmd_t                     cmd,
    input  logic [stwp_pkg::idx_w(POOL_SIZE)-1:0]    look_idx,
    output logic                                     look_active,
    output logic                                     free_found,
    output logic [stwp_pkg::idx_w(POOL_SIZE)-1:0]    free_idx
);
    import stwp_pkg::*;

    localparam int IdxW = idx_w(POOL_SIZE);

    logic [POOL_SIZE-1:0] active_reg;
    logic [POOL_SIZE-1:0] active_next;
    logic [IdxW-1:0]      cmd_idx;

    assign cmd_idx = cmd.idx[IdxW-1:0];

    // Apply claim or release to one flag
    always_comb
    begin
        active_next = active_reg;
        if (cmd.set_en)
        begin
            active_next[cmd_idx] = 1'b1;
        end
        if (cmd.clr_en)
        begin
            active_next[cmd_idx] = 1'b0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            active_reg <= '0;
        end
        else
        begin
            active_reg <= active_next;
        end
    end

    // Find the lowest inactive slot
    always_comb
    begin
        free_found = 1'b0;
        free_idx   = '0;
        for (int i = POOL_SIZE - 1; i >= 0; i--)
        begin
            if (!active_reg[i])
            begin
                free_found = 1'b1;
                free_idx   = IdxW'(i);
            end
        end
    end

    assign look_active = active_reg[look_idx];

endmodule

### rtl/core/stwp_slot_mem.sv
// Timeout and checkpoint memories of the timer pool, with registered read data.
// Depends on stwp_pkg.
`timescale 1ns / 1ps

module stwp_slot_mem #(
    parameter int POOL_SIZE = stwp_pkg::POOL_SIZE_DEF
) (
    input  logic                         clk,
    input  stwp_pkg::mem_cmd_t           cmd,
    input  logic [stwp_pkg::TIME_W-1:0]  wr_timeout,
    input  logic [stwp_pkg::TIME_W-1:0]  wr_checkpoint,
    output logic [stwp_pkg::TIME_W-1:0]  rd_timeout,
    output logic [stwp_pkg::TIME_W-1:0]  rd_checkpoint
);
    import stwp_pkg::*;

    localparam int IdxW = idx_w(POOL_SIZE);

    logic [TIME_W-1:0] timeout_mem    [POOL_SIZE];
    logic [TIME_W-1:0] checkpoint_mem [POOL_SIZE];
    logic [TIME_W-1:0] rd_timeout_reg;
    logic [TIME_W-1:0] rd_checkpoint_reg;
    logic [IdxW-1:0]   addr;

    assign addr = cmd.addr[IdxW-1:0];

    // Write stamps; data read from free slots is never used in a response
    always_ff @(posedge clk)
    begin
        if (cmd.wr_timeout)
        begin
            timeout_mem[addr] <= wr_timeout;
        end
        if (cmd.wr_checkpoint)
        begin
            checkpoint_mem[addr] <= wr_checkpoint;
        end
    end

    // Register read data
    always_ff @(posedge clk)
    begin
        if (cmd.rd_en)
        begin
            rd_timeout_reg    <= timeout_mem[addr];
            rd_checkpoint_reg <= checkpoint_mem[addr];
        end
    end

    assign rd_timeout    = rd_timeout_reg;
    assign rd_checkpoint = rd_checkpoint_reg;

endmodule

### rtl/core/stwp_count.sv
// Elapsed and remaining time arithmetic of the timer pool, one register stage.
// Depends on stwp_pkg.
`timescale 1ns / 1ps

module stwp_count (
    input  logic                         clk,
    input  logic                         load,
    input  logic [stwp_pkg::TIME_W-1:0]  now_ms,
    input  logic [stwp_pkg::TIME_W-1:0]  checkpoint,
    input  logic [stwp_pkg::TIME_W-1:0]  timeout,
    output logic [stwp_pkg::TIME_W-1:0]  count
);
    import stwp_pkg::*;

    logic [TIME_W-1:0] elapsed_reg;
    logic [TIME_W-1:0] limit_reg;
    logic [TIME_W:0]   remain;

    // Hold elapsed time (modulo wrap) and the limit
    always_ff @(posedge clk)
    begin
        if (load)
        begin
            elapsed_reg <= now_ms - checkpoint;
            limit_reg   <= timeout;
        end
    end

    // Borrow out of limit minus elapsed marks an expired countdown
    assign remain = {1'b0, limit_reg} - {1'b0, elapsed_reg};

    always_comb
    begin
        priority if (limit_reg == '0)
        begin
            count = elapsed_reg;
        end
        else if (remain[TIME_W] || (remain == '0))
        begin
            count = '0;
        end
        else
        begin
            count = remain[TIME_W-1:0];
        end
    end

endmodule

### rtl/core/stopwatch_timer_pool_top.sv
// Top level of the stopwatch timer pool: request decode, sequencer, output register.
// Depends on stwp_pkg, stwp_if, stwp_alloc, stwp_slot_mem, stwp_count.
//
//  Port  Dir  Word carried
//  ----  ---  ---------------------------------------------------
//  req   in   operation, timer_id, timeout_ms, now_ms
//  rsp   out  status, slot_granted, count_value
//
// A request word passes three steps: decode and memory access, elapsed-time
// subtract, remaining-time compare. The slot memories' single access port and
// this sequence admit no new request until the previous word has left the sequencer.
// Reset clears all active flags at once; no clearing pass is needed.
// A word waiting in the output register does not block the next request;
// a stalled rsp holds the sequencer in its last step until the register frees.
`timescale 1ns / 1ps

module stopwatch_timer_pool_top #(
    parameter int POOL_SIZE = stwp_pkg::POOL_SIZE_DEF
) (
    input  logic         clk,
    input  logic         rst_n,
    stwp_req_if.sink     req,
    stwp_rsp_if.source   rsp
);
    import stwp_pkg::*;

    localparam int IdxW = idx_w(POOL_SIZE);

    state_t            state_reg;
    state_t            state_next;
    logic              accept;
    op_t               op;
    logic              id_ok;
    logic [IdxW-1:0]   id_idx;
    logic              look_active;
    logic              free_found;
    logic [IdxW-1:0]   free_idx;
    alloc_cmd_t        alloc_cmd;
    mem_cmd_t          mem_cmd;
    logic [TIME_W-1:0] rd_timeout;
    logic [TIME_W-1:0] rd_checkpoint;
    logic [TIME_W-1:0] count;
    logic              out_load;

    status_t           dec_status;
    logic [ID_W-1:0]   dec_granted;
    logic              dec_query;

    status_t           status_reg;
    logic [ID_W-1:0]   granted_reg;
    logic              query_reg;
    logic [TIME_W-1:0] now_reg;

    logic              rsp_valid_reg;
    logic [ST_W-1:0]   rsp_status_reg;
    logic [ID_W-1:0]   rsp_granted_reg;
    logic [TIME_W-1:0] rsp_count_reg;

    assign req.ready = (state_reg == S_IDLE);
    assign accept    = req.valid && req.ready;
    assign op        = op_t'(req.operation);
    assign id_ok     = ({1'b0, req.timer_id} < (ID_W + 1)'(POOL_SIZE));
    assign id_idx    = req.timer_id[IdxW-1:0];

    // Decode the request against the active flags
    always_comb
    begin
        dec_status  = ST_OK;
        dec_granted = '0;
        dec_query   = 1'b0;
        alloc_cmd   = '0;
        mem_cmd     = '0;
        mem_cmd.addr = 6'(id_idx);
        unique case (op)
            OP_START:
            begin
                mem_cmd.addr = 6'(free_idx);
                if (free_found)
                begin
                    dec_granted           = {{(ID_W - IdxW){1'b0}}, free_idx};
                    alloc_cmd.set_en      = accept;
                    alloc_cmd.idx         = 6'(free_idx);
                    mem_cmd.wr_timeout    = accept;
                    mem_cmd.wr_checkpoint = accept;
                end
                else
                begin
                    dec_status = ST_FULL;
                end
            end
            OP_QUERY:
            begin
                mem_cmd.rd_en = accept;
                if (id_ok && look_active)
                begin
                    dec_query = 1'b1;
                end
                else
                begin
                    dec_status = ST_INVALID;
                end
            end
            OP_RESTART:
            begin
                if (id_ok)
                begin
                    mem_cmd.wr_checkpoint = accept;
                end
                else
                begin
                    dec_status = ST_INVALID;
                end
            end
            OP_CLOSE:
            begin
                if (id_ok)
                begin
                    alloc_cmd.clr_en = accept;
                    alloc_cmd.idx    = 6'(id_idx);
                end
                else
                begin
                    dec_status = ST_INVALID;
                end
            end
            default:
            begin
                dec_status = ST_INVALID;
            end
        endcase
    end

    stwp_alloc #(
        .POOL_SIZE (POOL_SIZE)
    ) u_alloc (
        .clk         (clk),
        .rst_n       (rst_n),
        .cmd         (alloc_cmd),
        .look_idx    (id_idx),
        .look_active (look_active),
        .free_found  (free_found),
        .free_idx    (free_idx)
    );

    stwp_slot_mem #(
        .POOL_SIZE (POOL_SIZE)
    ) u_slot_mem (
        .clk           (clk),
        .cmd           (mem_cmd),
        .wr_timeout    (req.timeout_ms),
        .wr_checkpoint (req.now_ms),
        .rd_timeout    (rd_timeout),
        .rd_checkpoint (rd_checkpoint)
    );

    stwp_count u_count (
        .clk        (clk),
        .load       (state_reg == S_READ),
        .now_ms     (now_reg),
        .checkpoint (rd_checkpoint),
        .timeout    (rd_timeout),
        .count      (count)
    );

    // Hold decoded request fields for the later steps
    always_ff @(posedge clk)
    begin
        if (accept)
        begin
            status_reg  <= dec_status;
            granted_reg <= dec_granted;
            query_reg   <= dec_query;
            now_reg     <= req.now_ms;
        end
    end

    // Sequencer
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= S_IDLE;
        end
        else
        begin
            state_reg <= state_next;
        end
    end

    always_comb
    begin
        state_next = state_reg;
        out_load   = 1'b0;
        unique case (state_reg)
            S_IDLE:
            begin
                if (accept)
                begin
                    state_next = S_READ;
                end
            end
            S_READ:
            begin
                state_next = S_CALC;
            end
            S_CALC:
            begin
                if (!rsp_valid_reg || rsp.ready)
                begin
                    out_load   = 1'b1;
                    state_next = S_IDLE;
                end
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    // Output register
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            rsp_valid_reg <= 1'b0;
        end
        else if (out_load)
        begin
            rsp_valid_reg <= 1'b1;
        end
        else if (rsp.ready)
        begin
            rsp_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge clk)
    begin
        if (out_load)
        begin
            rsp_status_reg  <= status_reg;
            rsp_granted_reg <= granted_reg;
            rsp_count_reg   <= query_reg ? count : '0;
        end
    end

    assign rsp.valid        = rsp_valid_reg;
    assign rsp.status       = rsp_status_reg;
    assign rsp.slot_granted = rsp_granted_reg;
    assign rsp.count_value  = rsp_count_reg;

endmodule

### rtl/core/stwp_checker.sv
// Port-level checks of the stopwatch timer pool and their bind to the top level.
// Depends on stwp_pkg and stopwatch_timer_pool_top.
`timescale 1ns / 1ps

module stwp_checker #(
    parameter int POOL_SIZE = stwp_pkg::POOL_SIZE_DEF
) (
    input logic                         clk,
    input logic                         rst_n,
    input logic                         req_valid,
    input logic                         req_ready,
    input logic                         rsp_valid,
    input logic                         rsp_ready,
    input logic [stwp_pkg::ST_W-1:0]    rsp_status,
    input logic [stwp_pkg::ID_W-1:0]    rsp_slot_granted,
    input logic [stwp_pkg::TIME_W-1:0]  rsp_count_value
);
    import stwp_pkg::*;

    // One request at a time: no accept right after an accept
    a_one_at_a_time: assert property (@(posedge clk) disable iff (!rst_n)
        (req_valid && req_ready) |=> !req_ready)
        else $error("request accepted while previous one in flight");

    // Stalled response word holds
    a_rsp_hold: assert property (@(posedge clk) disable iff (!rst_n)
        (rsp_valid && !rsp_ready) |=> (rsp_valid && $stable(rsp_status)
            && $stable(rsp_slot_granted) && $stable(rsp_count_value)))
        else $error("stalled response word changed");

    // Failed requests carry zero fields
    a_fail_zero: assert property (@(posedge clk) disable iff (!rst_n)
        (rsp_valid && (rsp_status != ST_W'(ST_OK)))
            |-> ((rsp_slot_granted == '0) && (rsp_count_value == '0)))
        else $error("failed request returned nonzero fields");

    // Granted slot lies inside the pool
    a_slot_range: assert property (@(posedge clk) disable iff (!rst_n)
        rsp_valid |-> ({1'b0, rsp_slot_granted} < (ID_W + 1)'(POOL_SIZE)))
        else $error("granted slot outside the pool");

endmodule

bind stopwatch_timer_pool_top stwp_checker #(
    .POOL_SIZE (POOL_SIZE)
) u_stwp_checker (
    .clk              (clk),
    .rst_n            (rst_n),
    .req_valid        (req.valid),
    .req_ready        (req.ready),
    .rsp_valid        (rsp.valid),
    .rsp_ready        (rsp.ready),
    .rsp_status       (rsp.status),
    .rsp_slot_granted (rsp.slot_granted),
    .rsp_count_value  (rsp.count_value)
);
